// ===== rtl/core/dsps_pkg.sv =====
// package for the dense shortest path search: sizes, codes, control words, microprogram
`timescale 1ns / 1ps

package dsps_pkg;

  // graph and datapath sizes
  localparam int MAX_NODES  = 256;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = NODE_W + 1;
  localparam int EDGE_DEPTH = MAX_NODES * MAX_NODES;
  localparam int WEIGHT_W   = 31;
  localparam int DIST_W     = 38;
  localparam int OUT_W      = 39;
  localparam int NCOUNT_W   = 9;
  localparam int PORTNODE_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int PC_W       = 4;

  localparam logic [DIST_W-1:0]   DIST_MAX     = '1;
  localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = NCOUNT_W'(256);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_SOURCE     = 2'd1,
    REG_TARGET     = 2'd2
  } cfg_reg_e;

  // datapath operations, one per microprogram step
  typedef enum logic [3:0] {
    OP_WAIT,
    OP_INIT,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_DECIDE,
    OP_RELAX_RD,
    OP_RELAX_UPD,
    OP_SETTLE,
    OP_EMIT,
    OP_NONE
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_SOLVE,
    COND_LOOP_END,
    COND_FINISH,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic solve_req;
    logic loop_end;
    logic finish;
    logic out_busy;
  } status_t;

  // step addresses
  localparam logic [PC_W-1:0] PC_WAIT      = 4'd0;
  localparam logic [PC_W-1:0] PC_INIT      = 4'd1;
  localparam logic [PC_W-1:0] PC_SCAN_RD   = 4'd2;
  localparam logic [PC_W-1:0] PC_SCAN_CMP  = 4'd3;
  localparam logic [PC_W-1:0] PC_DECIDE    = 4'd4;
  localparam logic [PC_W-1:0] PC_RELAX_RD  = 4'd5;
  localparam logic [PC_W-1:0] PC_RELAX_UPD = 4'd6;
  localparam logic [PC_W-1:0] PC_SETTLE    = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT      = 4'd8;
  localparam logic [PC_W-1:0] PC_RETURN    = 4'd9;
  localparam logic [PC_W-1:0] PC_LAST      = PC_RETURN;

  // microprogram: jump to target when the condition holds, else fall through
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_WAIT:      w = '{op: OP_WAIT,      cond: COND_NO_SOLVE, target: PC_WAIT};
      PC_INIT:      w = '{op: OP_INIT,      cond: COND_NEVER,    target: PC_WAIT};
      PC_SCAN_RD:   w = '{op: OP_SCAN_RD,   cond: COND_LOOP_END, target: PC_DECIDE};
      PC_SCAN_CMP:  w = '{op: OP_SCAN_CMP,  cond: COND_ALWAYS,   target: PC_SCAN_RD};
      PC_DECIDE:    w = '{op: OP_DECIDE,    cond: COND_FINISH,   target: PC_EMIT};
      PC_RELAX_RD:  w = '{op: OP_RELAX_RD,  cond: COND_LOOP_END, target: PC_SETTLE};
      PC_RELAX_UPD: w = '{op: OP_RELAX_UPD, cond: COND_ALWAYS,   target: PC_RELAX_RD};
      PC_SETTLE:    w = '{op: OP_SETTLE,    cond: COND_ALWAYS,   target: PC_SCAN_RD};
      PC_EMIT:      w = '{op: OP_EMIT,      cond: COND_OUT_BUSY, target: PC_EMIT};
      PC_RETURN:    w = '{op: OP_NONE,      cond: COND_ALWAYS,   target: PC_WAIT};
      default:      w = '{op: OP_NONE,      cond: COND_ALWAYS,   target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/dense_shortest_path_search.sv =====
// top level of the dense shortest path search
`timescale 1ns / 1ps

// Usage: the input channel (in_valid_i / in_stall_o) carries requests. A request
// with func_i low stores one adjacency entry weight_i for edge row_i -> col_i
// (a negative weight marks no edge); writes are taken back to back while idle.
// A request with func_i high runs a search from source_node to target_node over
// the first node_count nodes and yields one result on the output channel
// (out_valid_o / out_stall_i): the shortest distance, or -1 if unreachable.
// Every matrix entry a search reads must have been written before.
// Sequencing: the search is run by a microprogram over one edge ram and one
// distance ram. With N nodes in use, each settled node costs a minimum scan over
// the N nodes, a decide step, a relax pass over them and a settle step; a search
// keeps the input stalled until it returns to waiting for a request.
// The result sits in an output register; once it is loaded the next request is
// taken while the receiver stalls, and a later result waits in the emit step
// until the register frees. Reset clears control state, sets node_count to 256,
// source and target to 0; matrix contents are undefined until written. The user
// must make configuration writes only while idle; the block does not enforce it.

module dense_shortest_path_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dsps_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dsps_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 func_i,
  input  logic [dsps_pkg::PORTNODE_W-1:0]      row_i,
  input  logic [dsps_pkg::PORTNODE_W-1:0]      col_i,
  input  logic signed [dsps_pkg::WEIGHT_W-1:0] weight_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [dsps_pkg::OUT_W-1:0]    distance_o
);
  import dsps_pkg::*;

  ucode_t  ctrl;
  status_t status;

  // microprogram sequencer
  dsps_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // datapath and stores
  dsps_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .weight_i    (weight_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .distance_o  (distance_o)
  );

endmodule

// ===== rtl/core/dsps_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module dsps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dsps_seq.sv =====
// microprogram sequencer: step counter, control word table and conditional jumps
`timescale 1ns / 1ps

module dsps_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsps_pkg::status_t status_i,
  output dsps_pkg::ucode_t  ctrl_o
);
  import dsps_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          word;
  logic            jump;

  // fetch the control word of the current step
  assign word   = ucode_rom(pc_q);
  assign ctrl_o = word;

  // jump condition
  always_comb begin
    case (word.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_SOLVE: jump = !status_i.solve_req;
      COND_LOOP_END: jump = status_i.loop_end;
      COND_FINISH:   jump = status_i.finish;
      COND_OUT_BUSY: jump = status_i.out_busy;
      default:       jump = 1'b1;
    endcase
    pc_d = jump ? word.target : pc_q + 1'b1;
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef SYNTHESIS
  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_LAST)
    else $error("step counter left the program");
`endif

endmodule

// ===== rtl/core/dsps_datapath.sv =====
// search datapath: configuration, edge and distance rams, node flags, min scan and relax
`timescale 1ns / 1ps

module dsps_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dsps_pkg::ucode_t                     ctrl_i,
  output dsps_pkg::status_t                    status_o,
  input  logic                                 cfg_we_i,
  input  logic [dsps_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dsps_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 func_i,
  input  logic [dsps_pkg::PORTNODE_W-1:0]      row_i,
  input  logic [dsps_pkg::PORTNODE_W-1:0]      col_i,
  input  logic signed [dsps_pkg::WEIGHT_W-1:0] weight_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [dsps_pkg::OUT_W-1:0]    distance_o
);
  import dsps_pkg::*;

  logic [NCOUNT_W-1:0]   node_count_q;
  logic [PORTNODE_W-1:0] source_q, target_q;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [NODE_W-1:0]     idx;
  logic                  found_q, found_d;
  logic [NODE_W-1:0]     pick_q, pick_d;
  logic [DIST_W-1:0]     best_q, best_d;
  logic [MAX_NODES-1:0]  reached_q, reached_d;
  logic [MAX_NODES-1:0]  settled_q, settled_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      distance_q, distance_d;
  logic                  src_ok;

  logic                  edge_we;
  logic [WEIGHT_W-1:0]   edge_rdata;
  logic                  dist_we;
  logic [NODE_W-1:0]     dist_waddr;
  logic [DIST_W-1:0]     dist_wdata;
  logic [DIST_W-1:0]     dist_rdata;
  logic [DIST_W:0]       cand_sum;
  logic [DIST_W-1:0]     cand_sat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NCOUNT_RESET;
      source_q     <= '0;
      target_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NODE_COUNT: node_count_q <= cfg_data_i[NCOUNT_W-1:0];
        REG_SOURCE:     source_q     <= cfg_data_i[PORTNODE_W-1:0];
        REG_TARGET:     target_q     <= cfg_data_i[PORTNODE_W-1:0];
        default: ;
      endcase
    end
  end

  // nodes in use, clamped to the array size
  assign cnt    = (node_count_q > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(node_count_q);
  assign src_ok = 32'(source_q) < 32'(cnt);
  assign idx    = idx_q[NODE_W-1:0];

  // matrix writes are taken only while waiting for a request
  assign in_stall_o = (ctrl_i.op != OP_WAIT);
  assign edge_we    = in_valid_i && !in_stall_o && !func_i
                      && (32'(row_i) < MAX_NODES) && (32'(col_i) < MAX_NODES);

  dsps_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i ({NODE_W'(row_i), NODE_W'(col_i)}),
    .wdata_i ($unsigned(weight_i)),
    .raddr_i ({pick_q, idx}),
    .rdata_o (edge_rdata)
  );

  dsps_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_NODES)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (idx),
    .rdata_o (dist_rdata)
  );

  // candidate distance through the picked node, saturated
  assign cand_sum = {1'b0, best_q} + (DIST_W+1)'(edge_rdata[WEIGHT_W-2:0]);
  assign cand_sat = cand_sum[DIST_W] ? DIST_MAX : cand_sum[DIST_W-1:0];

  // operation decode
  always_comb begin
    idx_d       = idx_q;
    found_d     = found_q;
    pick_d      = pick_q;
    best_d      = best_q;
    reached_d   = reached_q;
    settled_d   = settled_q;
    distance_d  = distance_q;
    out_valid_d = out_valid_q && out_stall_i;
    dist_we     = 1'b0;
    dist_waddr  = idx;
    dist_wdata  = cand_sat;
    case (ctrl_i.op)
      OP_INIT: begin
        reached_d = '0;
        settled_d = '0;
        idx_d     = '0;
        found_d   = 1'b0;
        if (src_ok) begin
          reached_d[NODE_W'(source_q)] = 1'b1;
          dist_we    = 1'b1;
          dist_waddr = NODE_W'(source_q);
          dist_wdata = '0;
        end
      end
      OP_SCAN_CMP: begin
        if (reached_q[idx] && !settled_q[idx] && (!found_q || dist_rdata < best_q)) begin
          found_d = 1'b1;
          pick_d  = idx;
          best_d  = dist_rdata;
        end
        idx_d = idx_q + 1'b1;
      end
      OP_DECIDE: begin
        idx_d = '0;
      end
      OP_RELAX_UPD: begin
        // top weight bit set means no edge
        if (!settled_q[idx] && !edge_rdata[WEIGHT_W-1]
            && (!reached_q[idx] || cand_sat < dist_rdata)) begin
          reached_d[idx] = 1'b1;
          dist_we        = 1'b1;
        end
        idx_d = idx_q + 1'b1;
      end
      OP_SETTLE: begin
        settled_d[pick_q] = 1'b1;
        idx_d             = '0;
        found_d           = 1'b0;
      end
      OP_EMIT: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          distance_d  = found_q ? {1'b0, best_q} : '1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      found_q     <= 1'b0;
      reached_q   <= '0;
      settled_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      found_q     <= found_d;
      reached_q   <= reached_d;
      settled_q   <= settled_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pick_q     <= pick_d;
    best_q     <= best_d;
    distance_q <= distance_d;
  end

  // status back to the sequencer
  assign status_o.solve_req = in_valid_i && func_i;
  assign status_o.loop_end  = idx_q >= cnt;
  assign status_o.finish    = !found_q || (32'(pick_q) == 32'(target_q));
  assign status_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign distance_o  = $signed(distance_q);

`ifndef SYNTHESIS
  a_pick_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (reached_q[pick_q] && !settled_q[pick_q]))
    else $error("picked node is not a live candidate");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) <= MAX_NODES)
    else $error("node counter ran past the array");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.op == OP_EMIT))
    else $error("result appeared outside the emit step");
`endif

endmodule

// ===== tb/dense_shortest_path_search_test.sv =====
// self-checking testbench for the dense shortest path search: directed and random graphs
`timescale 1ns / 1ps

module dense_shortest_path_search_test;
  import dsps_pkg::*;

  // request codes and weight values
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SOLVE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic signed [WEIGHT_W-1:0] NO_EDGE = {WEIGHT_W{1'b1}};
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_LIMIT = 31'sd1000000000;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_TOP = 31'sh3FFF_FFFF;
  localparam logic [OUT_W-1:0] UNREACHABLE = '1;

  localparam int RANDOM_REQUESTS = 1200;
  localparam int SETTLE_CYCLES = 8;
  localparam int MISMATCH_REPORTS = 10;
  localparam longint TIMEOUT_NS = 40_000_000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]       cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic                        func_i = 1'b0;
  logic [PORTNODE_W-1:0]       row_i = '0;
  logic [PORTNODE_W-1:0]       col_i = '0;
  logic signed [WEIGHT_W-1:0]  weight_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [OUT_W-1:0]     distance_o;

  // shadow of the adjacency matrix and the search settings
  bit [WEIGHT_W-2:0]           edge_len [EDGE_DEPTH];
  bit                          edge_absent [EDGE_DEPTH];
  bit                          edge_known [EDGE_DEPTH];
  logic [NCOUNT_W-1:0]         node_count_set;
  logic [PORTNODE_W-1:0]       source_set;
  logic [PORTNODE_W-1:0]       target_set;
  logic [OUT_W-1:0]            distances_due [$];

  int requests_sent = 0;
  int writes_sent = 0;
  int searches_sent = 0;
  int cfg_writes = 0;
  int distances_checked = 0;
  int unreachable_seen = 0;
  int mismatch_count = 0;
  int burst_left = 0;
  int block_n = 0;
  int stall_window = 0;
  stall_mode_e stall_mode = STALL_NONE;

  dense_shortest_path_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .weight_i    (weight_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .distance_o  (distance_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // dijkstra over the shadow matrix; clean drops if any row read holds an unwritten entry
  function automatic logic [OUT_W-1:0] shortest_distance(output bit clean);
    logic [DIST_W-1:0] tent_dist [MAX_NODES];
    bit                seen [MAX_NODES];
    bit                done [MAX_NODES];
    logic [DIST_W-1:0] best;
    logic [DIST_W:0]   cand;
    int                n, i, pick, idx;
    bit                found;
    clean = 1'b1;
    n = (node_count_set > MAX_NODES) ? MAX_NODES : int'(node_count_set);
    for (i = 0; i < MAX_NODES; i++) begin
      tent_dist[i] = '0;
      seen[i] = 1'b0;
      done[i] = 1'b0;
    end
    if (int'(source_set) < n) seen[source_set] = 1'b1;
    forever begin
      // pick the closest open node, lowest index on a tie
      found = 1'b0;
      pick = 0;
      best = '0;
      for (i = 0; i < n; i++) begin
        if (seen[i] && !done[i] && (!found || tent_dist[i] < best)) begin
          found = 1'b1;
          pick = i;
          best = tent_dist[i];
        end
      end
      if (!found) return UNREACHABLE;
      if (pick == int'(target_set)) return {1'b0, best};
      // relax every edge out of the picked node
      for (i = 0; i < n; i++) begin
        idx = pick * MAX_NODES + i;
        if (!edge_known[idx]) clean = 1'b0;
        if (done[i] || edge_absent[idx]) continue;
        cand = {1'b0, best} + (DIST_W+1)'(edge_len[idx]);
        if (cand > {1'b0, DIST_MAX}) cand = {1'b0, DIST_MAX};
        if (!seen[i] || cand[DIST_W-1:0] < tent_dist[i]) begin
          seen[i] = 1'b1;
          tent_dist[i] = cand[DIST_W-1:0];
        end
      end
      done[pick] = 1'b1;
    end
  endfunction

  // sparse weights: many small values for ties, some large, negatives as no edge
  function automatic logic signed [WEIGHT_W-1:0] random_weight(input int density);
    int r;
    r = $urandom_range(0, 99);
    if (r >= density)
      return ($urandom_range(0, 4) == 0) ? {1'b1, 30'($urandom)} : NO_EDGE;
    r = $urandom_range(0, 9);
    if (r < 7) return WEIGHT_W'($urandom_range(0, 20));
    if (r < 9) return WEIGHT_W'($urandom_range(0, 1000000000));
    return {1'b0, 30'($urandom)};
  endfunction

  // send one request in bursts with random gaps, then update the shadow state
  task automatic send_request(input logic func, input logic [PORTNODE_W-1:0] row,
                              input logic [PORTNODE_W-1:0] col,
                              input logic signed [WEIGHT_W-1:0] weight);
    int gap;
    int idx;
    bit clean;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    func_i = func;
    row_i = row;
    col_i = col;
    weight_i = weight;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
    if (func == FUNC_SOLVE) begin
      searches_sent++;
      distances_due.push_back(shortest_distance(clean));
    end else begin
      writes_sent++;
      idx = int'(row) * MAX_NODES + int'(col);
      edge_known[idx] = 1'b1;
      edge_absent[idx] = weight[WEIGHT_W-1];
      edge_len[idx] = weight[WEIGHT_W-2:0];
    end
  endtask

  // hold the sender until every distance is back and the last write has landed
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (distances_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_writes++;
    case (index)
      REG_NODE_COUNT: node_count_set = data;
      REG_SOURCE:     source_set = data[PORTNODE_W-1:0];
      REG_TARGET:     target_set = data[PORTNODE_W-1:0];
      default: ;
    endcase
  endtask

  // node fields get a random unused top bit
  task automatic configure_search(input int count, input int src, input int tgt);
    wait_idle();
    cfg_write(REG_NODE_COUNT, CFG_DATA_W'(count));
    cfg_write(REG_SOURCE, {1'($urandom), PORTNODE_W'(src)});
    cfg_write(REG_TARGET, {1'($urandom), PORTNODE_W'(tgt)});
  endtask

  // reset settings: node 0 to itself needs no matrix reads
  task automatic test_reset_defaults();
    send_request(FUNC_SOLVE, 8'($urandom), 8'($urandom), 31'($urandom));
  endtask

  // three-node graph through the corner cases
  task automatic test_special_cases();
    configure_search(3, 0, 2);
    send_request(FUNC_WRITE, 0, 0, {1'b1, 30'd5});
    send_request(FUNC_WRITE, 0, 1, 0);
    send_request(FUNC_WRITE, 0, 2, NO_EDGE);
    send_request(FUNC_WRITE, 1, 0, WEIGHT_LIMIT);
    send_request(FUNC_WRITE, 1, 1, NO_EDGE);
    send_request(FUNC_WRITE, 1, 2, WEIGHT_TOP);
    send_request(FUNC_WRITE, 2, 0, 3);
    send_request(FUNC_WRITE, 2, 1, NO_EDGE);
    send_request(FUNC_WRITE, 2, 2, 0);
    send_request(FUNC_SOLVE, 0, 0, 0);
    // direct edge now beats the path through node 1
    send_request(FUNC_WRITE, 0, 2, WEIGHT_LIMIT);
    send_request(FUNC_SOLVE, 0, 0, 0);
    // target beyond node count
    configure_search(3, 0, 5);
    send_request(FUNC_SOLVE, 0, 0, 0);
    // source beyond node count, equal to target
    configure_search(3, 7, 7);
    send_request(FUNC_SOLVE, 0, 0, 0);
    // no nodes in use
    configure_search(0, 0, 0);
    send_request(FUNC_SOLVE, 0, 0, 0);
    // source equals target
    configure_search(3, 2, 2);
    send_request(FUNC_SOLVE, 0, 0, 0);
    configure_search(3, 1, 0);
    send_request(FUNC_SOLVE, 0, 0, 0);
    // unused register index leaves the settings alone
    configure_search(3, 2, 0);
    cfg_write(REG_SPARE, '1);
    send_request(FUNC_SOLVE, 0, 0, 0);
  endtask

  // all 256 nodes in use: only the row of node 255 is ever read
  task automatic test_full_size_graph();
    int c;
    configure_search(MAX_NODES, MAX_NODES - 1, 0);
    for (c = 0; c < MAX_NODES; c++)
      send_request(FUNC_WRITE, PORTNODE_W'(MAX_NODES - 1), PORTNODE_W'(c),
                   (c == 0) ? WEIGHT_LIMIT :
                   (c == MAX_NODES - 2) ? {1'b1, 30'($urandom)} : NO_EDGE);
    send_request(FUNC_SOLVE, 0, 0, 0);
    // counts above the maximum act as the maximum
    configure_search(300, MAX_NODES - 1, 0);
    send_request(FUNC_SOLVE, 0, 0, 0);
    configure_search(511, MAX_NODES - 1, MAX_NODES - 1);
    send_request(FUNC_SOLVE, 0, 0, 0);
    configure_search(MAX_NODES, MAX_NODES - 1, 0);
    send_request(FUNC_WRITE, PORTNODE_W'(MAX_NODES - 1), 0, NO_EDGE);
    send_request(FUNC_SOLVE, 0, 0, 0);
  endtask

  // random graphs on the low nodes, random settings, searches mixed with edits
  task automatic test_random_graphs();
    int first, density, r, cnt, src, tgt, rr, cc;
    bit clean;
    first = requests_sent;
    density = 50;
    block_n = 0;
    while (requests_sent - first < RANDOM_REQUESTS) begin
      // fresh graph now and then
      if (block_n == 0 || $urandom_range(0, 99) < 25) begin
        block_n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
        density = $urandom_range(10, 90);
        for (rr = 0; rr < block_n; rr++)
          for (cc = 0; cc < block_n; cc++)
            send_request(FUNC_WRITE, PORTNODE_W'(rr), PORTNODE_W'(cc),
                         random_weight(density));
      end
      // settings mostly inside the written block
      r = $urandom_range(0, 99);
      if (r < 8) cnt = 0;
      else if (r < 16) cnt = $urandom_range(MAX_NODES + 1, 511);
      else if (r < 30) cnt = $urandom_range(block_n + 1, block_n + 6);
      else cnt = $urandom_range(1, block_n);
      if (cnt > MAX_NODES && $urandom_range(0, 1) == 1) src = MAX_NODES - 1;
      else if ($urandom_range(0, 99) < 85) src = $urandom_range(0, block_n - 1);
      else src = $urandom_range(0, 255);
      if ($urandom_range(0, 99) < 15) tgt = src;
      else if ($urandom_range(0, 99) < 85) tgt = $urandom_range(0, block_n - 1);
      else tgt = $urandom_range(0, 255);
      configure_search(cnt, src, tgt);
      // searches only where every matrix row read has been written
      repeat ($urandom_range(3, 12)) begin
        void'(shortest_distance(clean));
        if (clean && $urandom_range(0, 99) < 45)
          send_request(FUNC_SOLVE, 8'($urandom), 8'($urandom), 31'($urandom));
        else if ($urandom_range(0, 99) < 70)
          send_request(FUNC_WRITE, PORTNODE_W'($urandom_range(0, block_n - 1)),
                       PORTNODE_W'($urandom_range(0, block_n - 1)), random_weight(density));
        else
          send_request(FUNC_WRITE, 8'($urandom), 8'($urandom), random_weight(density));
      end
    end
  endtask

  // receiver stall pattern, switching mode every window
  always @(negedge clk_i) begin
    if (stall_window == 0) begin
      stall_window = $urandom_range(16, 120);
      stall_mode = stall_mode_e'($urandom_range(0, 3));
    end
    stall_window--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 99) < 80);
      default:     out_stall_i <= ((stall_window % 8) < 5);
    endcase
  end

  // compare each accepted distance with the oldest prediction
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (distances_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MISMATCH_REPORTS)
          $display("%0t: distance %0d with no search pending", $time, distance_o);
      end else begin
        want = distances_due.pop_front();
        distances_checked++;
        if (want == UNREACHABLE) unreachable_seen++;
        if (distance_o !== want) begin
          mismatch_count++;
          if (mismatch_count <= MISMATCH_REPORTS)
            $display("%0t: distance expected %0d got %0d", $time, $signed(want), distance_o);
        end
      end
    end
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    node_count_set = NCOUNT_RESET;
    source_set = '0;
    target_set = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_special_cases();
    test_full_size_graph();
    test_random_graphs();
    wait_idle();
    $display("covered %0d requests: %0d matrix writes, %0d searches, %0d register writes",
             requests_sent, writes_sent, searches_sent, cfg_writes);
    $display("checked %0d distances, %0d unreachable, %0d wrong",
             distances_checked, unreachable_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
